/* design/kwc_pkg.sv */
// package for the keyed word checksum unit: constants and helper functions
package kwc_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned RAW_KEY_W   = 16;
  localparam int unsigned KEY_W       = 10;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned PHASE_W     = 4;
  localparam int unsigned RSHIFT_W    = 5;

  localparam logic [RAW_KEY_W-1:0] KEY_XOR       = 16'hB479;
  localparam logic [3:0]           KEY_LOW_MASK  = 4'hF;
  localparam int unsigned          KEY_HIGH_SHIFT = 10;
  localparam int unsigned          ACC_SEED_SHIFT = 9;
  localparam logic [RSHIFT_W-1:0]  RSHIFT_BASE   = 5'd3;

  // operation codes picked by the op phase
  localparam logic [OP_W-1:0] OP_XOR   = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
  localparam logic [OP_W-1:0] OP_SHXOR = 2'd2;

  // reciprocal of 11 scaled by 2^15, exact floor for sums below 2^15
  localparam logic [11:0] RECIP11       = 12'd2979;
  localparam int unsigned RECIP11_SHIFT = 15;
  localparam logic [3:0]  MOD11         = 4'd11;

  typedef logic [KEY_W-1:0] key_t;

  // t = raw ^ 0xB479, key = {t[15:10], t[3:0]}
  function automatic key_t descramble(input logic [RAW_KEY_W-1:0] raw);
    logic [RAW_KEY_W-1:0] t;
    t = raw ^ KEY_XOR;
    return {t[RAW_KEY_W-1:KEY_HIGH_SHIFT], t[3:0] & KEY_LOW_MASK};
  endfunction

  // 4 = 1 mod 3, so the base-4 digit sum keeps the residue
  function automatic logic [OP_W-1:0] key_mod3(input key_t k);
    logic [3:0] s1;
    logic [2:0] s2;
    s1 = 4'(k[1:0]) + 4'(k[3:2]) + 4'(k[5:4]) + 4'(k[7:6]) + 4'(k[9:8]);
    s2 = 3'(s1[1:0]) + 3'(s1[3:2]);
    if (s2 >= 3'd3) begin
      s2 = s2 - 3'd3;
    end
    if (s2 >= 3'd3) begin
      s2 = s2 - 3'd3;
    end
    return s2[OP_W-1:0];
  endfunction

  // 1024 = 1 mod 11: fold 10-bit chunks, then reciprocal multiply
  function automatic logic [3:0] word_mod11(input logic [WORD_W-1:0] w);
    logic [11:0] s;
    logic [23:0] prod;
    logic [8:0]  q;
    logic [11:0] r;
    s    = 12'(w[9:0]) + 12'(w[19:10]) + 12'(w[29:20]) + 12'(w[31:30]);
    prod = 24'(s) * 24'(RECIP11);
    q    = prod[23:RECIP11_SHIFT];
    r    = s - 12'(12'(q) * 12'(MOD11));
    return r[3:0];
  endfunction

endpackage

/* design/keyed_word_checksum_unit.sv */
// top level of the keyed word checksum unit
//
// Streams a message as 32-bit words (bytes little-endian), last word flagged
// by s_tlast, and returns one 32-bit keyed checksum on the master side after
// each last word. The unit takes one word per cycle while the input side is
// not stalled: a word sits in an input register, the whole per-word update
// (mod-3 op select, mod-11 shift, add and xor fold) runs combinationally from
// that register into the accumulator, and a last word also loads the result
// register, which drives m_tvalid. The input side stalls only while a finished
// checksum waits in the result register and the next buffered word is again a
// last word. The raw key is written through the cfg channel (always ready);
// the user must write it only while no word request is buffered, which the
// block itself does not enforce; a write may land between messages or in the
// middle of one. The key is descrambled at every word for the xor fold, and it
// seeds the accumulator and the op phase at the first word of each message only.
module keyed_word_checksum_unit
  import kwc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [RAW_KEY_W-1:0] cfg_data,   // raw_key[15:0]
  // input word stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [WORD_W-1:0]    s_tdata,    // data_word[31:0]
  input  logic                 s_tlast,    // last_word
  // checksum stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [WORD_W-1:0]    m_tdata     // checksum[31:0]
);

  // key register
  logic [RAW_KEY_W-1:0] raw_key;

  // input register
  logic              in_valid;
  logic [WORD_W-1:0] in_word;
  logic              in_last;

  // running state
  logic [WORD_W-1:0] acc;
  logic              msg_start;
  logic [OP_W-1:0]   op_phase;
  logic [PHASE_W-1:0] shift_phase;

  // result register
  logic              out_valid;
  logic [WORD_W-1:0] out_sum;

  // datapath
  key_t               key;
  logic [WORD_W-1:0]  acc_base;
  logic [OP_W-1:0]    op_cur;
  logic [PHASE_W-1:0] sh_cur;
  logic [3:0]         lshift;
  logic [WORD_W-1:0]  acc_op;
  logic [WORD_W-1:0]  fold_sum;
  logic [RSHIFT_W-1:0] rshift;
  logic [WORD_W-1:0]  acc_next;
  logic [OP_W-1:0]    op_phase_next;
  logic               process;

  assign cfg_ready = 1'b1;

  // a last word may only move on when the result register is free or draining
  assign process  = in_valid && (!in_last || !out_valid || m_tready);
  assign s_tready = !in_valid || process;

  assign m_tvalid = out_valid;
  assign m_tdata  = out_sum;

  always_comb begin
    key      = descramble(raw_key);
    // first word of a message reloads the seed and restarts both phases
    acc_base = msg_start ? (WORD_W'(key) << ACC_SEED_SHIFT) : acc;
    op_cur   = msg_start ? key_mod3(key) : op_phase;
    sh_cur   = msg_start ? '0 : shift_phase;
    lshift   = word_mod11(in_word);

    case (op_cur)
      OP_XOR:   acc_op = acc_base ^ in_word;
      OP_ADD:   acc_op = acc_base + in_word;
      OP_SHXOR: acc_op = (acc_base << lshift) ^ in_word;
      default:  acc_op = (acc_base << lshift) ^ in_word;
    endcase

    fold_sum = WORD_W'(key) + acc_op;
    rshift   = RSHIFT_W'(sh_cur) + RSHIFT_BASE;
    acc_next = acc_op ^ (fold_sum >> rshift);

    // wrap the op phase through 0, 1, 2
    op_phase_next = (op_cur == OP_SHXOR) ? OP_XOR : op_cur + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_key <= '0;
    end else if (cfg_valid && cfg_ready) begin
      raw_key <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_word <= s_tdata;
      in_last <= s_tlast;
    end
  end

  // checksum state
  always_ff @(posedge clk) begin
    if (rst) begin
      acc         <= '0;
      msg_start   <= 1'b1;
      op_phase    <= OP_XOR;
      shift_phase <= '0;
    end else if (process) begin
      acc         <= acc_next;
      msg_start   <= in_last;
      op_phase    <= op_phase_next;
      shift_phase <= sh_cur + 4'd1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (process && in_last) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (process && in_last) begin
      out_sum <= acc_next;
    end
  end

endmodule
